// File: hdl/assert_macros.svh
// Assertion macros shared by the covariance accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence on the same clock edge.
`define SCA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that an expression holds at every clock edge outside reset.
`define SCA_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

// File: hdl/sca_pkg.sv
// Shared constants, types and helpers for the covariance accumulator.
package sca_pkg;

  localparam int BINS       = 257;
  localparam int CHANNELS   = 4;
  localparam int ENTRIES    = BINS * CHANNELS * CHANNELS;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int BIN_W      = 9;
  localparam int ADDR_W     = $clog2(ENTRIES);
  localparam int ACC_W      = 48;
  localparam int VAL_W      = 16;
  localparam int W_W        = 16;
  localparam int CFG_CH_W   = 3;
  localparam int WEIGHT_ONE = 32768;
  localparam int ROUND_HALF = 16384;
  localparam int SCALE_SH   = 15;

  // Register indexes on the configuration port
  localparam logic REG_WEIGHT   = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              latch;
    logic              chan_wr;
    logic              issue;
    logic              first;
    logic [CH_W-1:0]   pair_row;
    logic [CH_W-1:0]   pair_col;
    logic              rd_issue;
    logic              res_load;
    logic              clr_wr;
    logic              sweep_wr;
    logic [ADDR_W-1:0] sweep_addr;
  } sca_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_t cmd;
    logic row_ok;
    logic trigger;
    logic bad;
    logic pipe_busy;
    logic out_free;
  } sca_stat_t;

  // Entry (bin,row,col) sits at (bin*CHANNELS+row)*CHANNELS+col
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [BIN_W-1:0] bin,
                                                   input logic [CH_W-1:0] row,
                                                   input logic [CH_W-1:0] col);
    logic [BIN_W+2*CH_W-1:0] full;
    full = {bin, row, col};
    return full[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/spatial_covariance_accumulator.sv
// Spatial covariance accumulator: top level joining registers, controller and datapath.
//
// Input stream (s_*): one command per transfer. Accumulate transfers buffer one
// channel's value for a bin; the transfer for the last channel in use starts an
// update of every upper-triangle entry of that bin. Read transfers return one
// entry on the output stream (m_*); clear transfers zero one entry.
// An accumulate or clear that starts no update leaves the controller idle and
// ready for the next transfer. A triggering accumulate issues the P pairs of
// the upper triangle in turn (P = 10 at four channels) and then waits in the
// drain state until the update pipeline is empty before it takes the next
// transfer. A read waits in the response state until the output register is
// free, loads its result there, and only then takes the next transfer.
// After reset the store is zeroed one entry a cycle, all 4112 entries, during
// which s_tready stays low; configuration writes are taken throughout.
// A stalled result is held in the output register; only a read that finds the
// register still full waits, with s_tready low, until the result is taken.
// Configure weight and channels_in_use over the APB port only while idle.
`include "assert_macros.svh"

module spatial_covariance_accumulator (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // bin[8:0], row_channel[10:9], col_channel[12:11],
                                 // value_re[28:13], value_im[44:29], zero[47:45]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // sum_re[47:0], sum_im[95:48]
  output logic        m_tuser,   // status[0]
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sca_pkg::*;

  logic [W_W-1:0]      weight_eff;
  logic [CFG_CH_W-1:0] chan_eff;
  sca_ctl_t            ctl;
  sca_stat_t           stat;

  sca_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .weight_eff (weight_eff),
    .chan_eff   (chan_eff)
  );

  sca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .chan_eff (chan_eff),
    .stat     (stat),
    .ctl      (ctl)
  );

  sca_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .s_tuser    (s_tuser),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .weight_eff (weight_eff),
    .chan_eff   (chan_eff),
    .ctl        (ctl),
    .stat       (stat)
  );

  // A new transfer never meets an update still in flight
  `SCA_ASSERT_IMP(a_accept_drained, clk, rst, s_tvalid && s_tready, !stat.pipe_busy, "transfer accepted during update")
  // A result is only loaded into a free output register
  `SCA_ASSERT_IMP(a_load_free, clk, rst, ctl.res_load, stat.out_free, "result overwrites pending result")
  // Store and buffer operations never collide
  `SCA_ASSERT_ALWAYS(a_one_op, clk, rst, $onehot0({ctl.sweep_wr, ctl.clr_wr, ctl.chan_wr, ctl.rd_issue, ctl.issue}), "colliding datapath commands")

endmodule

// File: hdl/sca_regs.sv
// Configuration register file with APB-style access and clamped outputs.
module sca_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [sca_pkg::W_W-1:0]      weight_eff,
  output logic [sca_pkg::CFG_CH_W-1:0] chan_eff
);
  import sca_pkg::*;

  logic [W_W-1:0]      weight;
  logic [CFG_CH_W-1:0] chan_cfg;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write registers at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      weight   <= W_W'(WEIGHT_ONE);
      chan_cfg <= CFG_CH_W'(CHANNELS);
    end else if (wr_en) begin
      if (paddr[2] == REG_WEIGHT) begin
        weight <= pwdata[W_W-1:0];
      end else begin
        chan_cfg <= pwdata[CFG_CH_W-1:0];
      end
    end
  end

  // Read back the addressed register
  always_comb begin
    if (paddr[2] == REG_CHANNELS) begin
      prdata = {{(32-CFG_CH_W){1'b0}}, chan_cfg};
    end else begin
      prdata = {{(32-W_W){1'b0}}, weight};
    end
  end

  // Clamp the weight to one and the channel count to its legal range
  always_comb begin
    if (weight > W_W'(WEIGHT_ONE)) begin
      weight_eff = W_W'(WEIGHT_ONE);
    end else begin
      weight_eff = weight;
    end
    if (chan_cfg == '0) begin
      chan_eff = CFG_CH_W'(1);
    end else if (chan_cfg > CFG_CH_W'(CHANNELS)) begin
      chan_eff = CFG_CH_W'(CHANNELS);
    end else begin
      chan_eff = chan_cfg;
    end
  end

endmodule

// File: hdl/sca_ctrl.sv
// Controller: reset sweep, command dispatch and pair sequencing.
module sca_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sca_pkg::CFG_CH_W-1:0] chan_eff,
  input  sca_pkg::sca_stat_t           stat,
  output sca_pkg::sca_ctl_t            ctl
);
  import sca_pkg::*;

  state_t              state, state_next;
  logic [CH_W-1:0]     pair_row, pair_row_next;
  logic [CH_W-1:0]     pair_col, pair_col_next;
  logic [ADDR_W-1:0]   sweep_addr, sweep_addr_next;
  logic [CFG_CH_W-1:0] last_ch;

  assign last_ch = chan_eff - CFG_CH_W'(1);

  // State and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      pair_row   <= '0;
      pair_col   <= '0;
      sweep_addr <= '0;
    end else begin
      state      <= state_next;
      pair_row   <= pair_row_next;
      pair_col   <= pair_col_next;
      sweep_addr <= sweep_addr_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    pair_row_next   = pair_row;
    pair_col_next   = pair_col;
    sweep_addr_next = sweep_addr;
    s_tready        = 1'b0;
    ctl             = '0;
    ctl.pair_row    = pair_row;
    ctl.pair_col    = pair_col;
    ctl.sweep_addr  = sweep_addr;

    case (state)
      ST_SWEEP: begin
        // Zero one entry a cycle until the whole store is clear
        ctl.sweep_wr    = 1'b1;
        sweep_addr_next = sweep_addr + ADDR_W'(1);
        if (sweep_addr == ADDR_W'(ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.latch = 1'b1;
          case (stat.cmd)
            CMD_ACC: begin
              ctl.chan_wr = stat.row_ok;
              if (stat.trigger) begin
                pair_row_next = '0;
                pair_col_next = '0;
                state_next    = ST_ISSUE;
              end
            end
            CMD_READ: begin
              ctl.rd_issue = !stat.bad;
              state_next   = ST_RESP;
            end
            CMD_CLEAR: begin
              ctl.clr_wr = !stat.bad;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ISSUE: begin
        // Walk the upper triangle, one pair a cycle
        ctl.issue = 1'b1;
        ctl.first = (pair_row == pair_col);
        if (CFG_CH_W'(pair_col) == last_ch) begin
          pair_row_next = pair_row + CH_W'(1);
          pair_col_next = pair_row + CH_W'(1);
          if (CFG_CH_W'(pair_row) == last_ch) begin
            state_next = ST_DRAIN;
          end
        end else begin
          pair_col_next = pair_col + CH_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESP: begin
        // Hold the read data until the output register is free
        if (stat.out_free) begin
          ctl.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/sca_datapath.sv
// Datapath: channel buffer, update pipeline, covariance store and result register.
module sca_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   s_tuser,
  input  logic [47:0]                  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [95:0]                  m_tdata,
  output logic                         m_tuser,
  input  logic [sca_pkg::W_W-1:0]      weight_eff,
  input  logic [sca_pkg::CFG_CH_W-1:0] chan_eff,
  input  sca_pkg::sca_ctl_t            ctl,
  output sca_pkg::sca_stat_t           stat
);
  import sca_pkg::*;

  localparam int PW = 2 * VAL_W + 1;    // complex product part
  localparam int SW = PW + W_W + 1;     // after weighting
  localparam int RW = SW - SCALE_SH;    // after rounding

  // Input fields
  logic [BIN_W-1:0]        in_bin;
  logic [CH_W-1:0]         in_row, in_col;
  logic [2*VAL_W-1:0]      in_val;
  logic [ADDR_W-1:0]       in_addr;
  logic                    row_ok, col_ok, bin_ok;

  // Latched item
  logic [BIN_W-1:0]        bin_q;
  logic                    bad_q;

  // Channel buffer and row operand
  logic [2*VAL_W-1:0]      chan_val [CHANNELS];
  logic [2*VAL_W-1:0]      col_val;
  logic [2*VAL_W-1:0]      row_val;

  // Pipeline
  logic                    v1, v2, v3, v4, v5;
  logic [ADDR_W-1:0]       a1, a2, a3, a4, a5;
  logic signed [VAL_W-1:0] x_re, x_im, y_re, y_im;
  logic signed [2*VAL_W-1:0] m_rr, m_ii, m_ir, m_ri;
  logic signed [PW-1:0]    p_re, p_im;
  logic signed [SW-1:0]    s_re, s_im;
  logic signed [SW-1:0]    s_re_rnd, s_im_rnd;
  logic signed [RW-1:0]    r_re, r_im;
  logic signed [W_W:0]     w_s;
  logic signed [ACC_W:0]   sum_re, sum_im;
  logic [ACC_W-1:0]        sat_re, sat_im;

  // Store
  logic [2*ACC_W-1:0]      mem [ENTRIES];
  logic [2*ACC_W-1:0]      rdata;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       waddr, raddr;
  logic [2*ACC_W-1:0]      wdata;

  // Decode the incoming item
  assign in_bin  = s_tdata[BIN_W-1:0];
  assign in_row  = s_tdata[BIN_W+CH_W-1:BIN_W];
  assign in_col  = s_tdata[BIN_W+2*CH_W-1:BIN_W+CH_W];
  assign in_val  = s_tdata[BIN_W+2*CH_W+2*VAL_W-1:BIN_W+2*CH_W];
  assign in_addr = entry_addr(in_bin, in_row, in_col);
  assign row_ok  = CFG_CH_W'(in_row) < chan_eff;
  assign col_ok  = CFG_CH_W'(in_col) < chan_eff;
  assign bin_ok  = in_bin < BIN_W'(BINS);

  assign stat.cmd       = cmd_t'(s_tuser);
  assign stat.row_ok    = row_ok;
  assign stat.trigger   = row_ok && bin_ok && (CFG_CH_W'(in_row) == chan_eff - CFG_CH_W'(1));
  assign stat.bad       = !bin_ok || (in_row > in_col) || !row_ok || !col_ok;
  assign stat.pipe_busy = v1 || v2 || v3 || v4 || v5;
  assign stat.out_free  = !m_tvalid || m_tready;

  // Hold the accepted item's bin and address check
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      bin_q <= in_bin;
      bad_q <= stat.bad;
    end
  end

  // Buffer the channel value
  always_ff @(posedge clk) begin
    if (ctl.chan_wr) begin
      chan_val[in_row] <= in_val;
    end
  end

  assign col_val = chan_val[ctl.pair_col];

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Operand fetch: the row value is taken when its diagonal pair is issued
  always_ff @(posedge clk) begin
    if (ctl.issue && ctl.first) begin
      row_val <= col_val;
    end
    y_re <= col_val[VAL_W-1:0];
    y_im <= col_val[2*VAL_W-1:VAL_W];
    if (ctl.first) begin
      x_re <= col_val[VAL_W-1:0];
      x_im <= col_val[2*VAL_W-1:VAL_W];
    end else begin
      x_re <= row_val[VAL_W-1:0];
      x_im <= row_val[2*VAL_W-1:VAL_W];
    end
    a1 <= entry_addr(bin_q, ctl.pair_row, ctl.pair_col);
  end

  assign w_s = {1'b0, weight_eff};

  // Multiply, combine, weight and round
  always_ff @(posedge clk) begin
    m_rr <= x_re * y_re;
    m_ii <= x_im * y_im;
    m_ir <= x_im * y_re;
    m_ri <= x_re * y_im;
    a2   <= a1;

    p_re <= PW'(m_rr) + PW'(m_ii);
    p_im <= PW'(m_ir) - PW'(m_ri);
    a3   <= a2;

    s_re <= p_re * w_s;
    s_im <= p_im * w_s;
    a4   <= a3;

    r_re <= s_re_rnd[SW-1:SCALE_SH];
    r_im <= s_im_rnd[SW-1:SCALE_SH];
    a5   <= a4;
  end

  assign s_re_rnd = s_re + SW'(ROUND_HALF);
  assign s_im_rnd = s_im + SW'(ROUND_HALF);

  // Saturating add onto the stored entry
  assign sum_re = (ACC_W+1)'(r_re) + {rdata[ACC_W-1], rdata[ACC_W-1:0]};
  assign sum_im = (ACC_W+1)'(r_im) + {rdata[2*ACC_W-1], rdata[2*ACC_W-1:ACC_W]};

  always_comb begin
    if (sum_re[ACC_W] != sum_re[ACC_W-1]) begin
      sat_re = {sum_re[ACC_W], {(ACC_W-1){!sum_re[ACC_W]}}};
    end else begin
      sat_re = sum_re[ACC_W-1:0];
    end
    if (sum_im[ACC_W] != sum_im[ACC_W-1]) begin
      sat_im = {sum_im[ACC_W], {(ACC_W-1){!sum_im[ACC_W]}}};
    end else begin
      sat_im = sum_im[ACC_W-1:0];
    end
  end

  // Store port selection
  always_comb begin
    mem_we = ctl.sweep_wr || ctl.clr_wr || v5;
    wdata  = {sat_im, sat_re};
    waddr  = a5;
    if (ctl.sweep_wr) begin
      waddr = ctl.sweep_addr;
      wdata = '0;
    end else if (ctl.clr_wr) begin
      waddr = in_addr;
      wdata = '0;
    end
    mem_re = ctl.rd_issue || v4;
    raddr  = ctl.rd_issue ? in_addr : a4;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      m_tdata <= bad_q ? '0 : rdata;
      m_tuser <= bad_q;
    end
  end

endmodule
